### hdl/kwm_pkg.sv
// kwm_pkg: shared types and codes for the k-way sorted merge engine.
// No dependencies.
package kwm_pkg;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_TAKE   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    // control from the sequencer to the head compare unit
    typedef struct packed {
        logic init;   // forget the current best
        logic cand;   // a head word is on the compare input
    } t_best_ctl;

endpackage

### hdl/kwm_mem.sv
// kwm_mem: list buffer storage, one write port and one registered read port.
// No dependencies.
module kwm_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/kwm_best.sv
// kwm_best: shared signed comparator that keeps the smallest head seen so far.
// Depends on kwm_pkg.
module kwm_best #(
    parameter int LW = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kwm_pkg::t_best_ctl  i_ctl,
    input  logic [31:0]         i_data,
    input  logic [LW-1:0]       i_idx,
    output logic                o_found,
    output logic [31:0]         o_value,
    output logic [LW-1:0]       o_idx
);

    logic n_take;

    // strict less-than keeps the lowest list on equal heads
    assign n_take = i_ctl.cand && (!o_found || ($signed(i_data) < $signed(o_value)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            o_found <= 1'b0;
        end else if (n_take) begin
            o_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            o_value <= i_data;
            o_idx   <= i_idx;
        end
    end

endmodule

### hdl/k_way_sorted_merge_top.sv
// k_way_sorted_merge_top: merge engine for NUM_LISTS ascending lists.
// A take scans every list in S_SCAN, then S_LAST and S_DONE; its registered
// strobe follows S_DONE. Busy is high in these states, one list head compared
// per cycle by one comparator; an append holds busy in S_APPEND and a clear
// leaves it low. Words are taken only while idle. Reset (synchronous, active
// low) empties all lists; the result strobe cannot be stalled by the receiver.
module k_way_sorted_merge_top #(
    parameter int NUM_LISTS  = 8,
    parameter int LIST_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_list_id,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [31:0] o_out_value,
    output logic [2:0]  o_out_list,
    output logic        o_all_empty
);

    localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int PW    = $clog2(LIST_DEPTH + 1);
    localparam int DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    kwm_pkg::t_state    r_state, n_state;
    kwm_pkg::t_best_ctl s_ctl;

    logic [LW-1:0] r_idx, n_idx;
    logic          r_id_ok;
    logic [31:0]   r_value;
    logic [PW-1:0] r_rp [NUM_LISTS];
    logic [PW-1:0] r_wp [NUM_LISTS];
    logic          r_pv;
    logic [LW-1:0] r_pidx;

    logic          s_accept;
    logic          s_clear;
    logic          s_we;
    logic          s_head;
    logic          s_pop;
    logic [AW-1:0] s_base;
    logic [AW-1:0] s_waddr;
    logic [AW-1:0] s_raddr;
    logic [31:0]   s_rdata;
    logic          s_found;
    logic [31:0]   s_best;
    logic [LW-1:0] s_best_idx;

    assign busy     = (r_state != kwm_pkg::S_IDLE);
    assign s_accept = start && !busy;
    assign s_clear  = s_accept && (kwm_pkg::t_action'(i_action) == kwm_pkg::ACT_CLEAR);

    assign s_base  = AW'(r_idx) * AW'(LIST_DEPTH);
    assign s_waddr = s_base + AW'(r_wp[r_idx]);
    assign s_raddr = s_base + AW'(r_rp[r_idx]);
    assign s_head  = r_rp[r_idx] < r_wp[r_idx];
    assign s_we    = (r_state == kwm_pkg::S_APPEND) && r_id_ok
                     && (32'(r_wp[r_idx]) < LIST_DEPTH);
    assign s_pop   = (r_state == kwm_pkg::S_DONE) && s_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        s_ctl.init = 1'b0;
        s_ctl.cand = 1'b0;
        unique case (r_state)
            kwm_pkg::S_IDLE: begin
                if (s_accept) begin
                    case (kwm_pkg::t_action'(i_action))
                        kwm_pkg::ACT_APPEND: begin
                            n_state = kwm_pkg::S_APPEND;
                            n_idx   = LW'(i_list_id);
                        end
                        kwm_pkg::ACT_TAKE: begin
                            n_state    = kwm_pkg::S_SCAN;
                            n_idx      = '0;
                            s_ctl.init = 1'b1;
                        end
                        default: n_state = kwm_pkg::S_IDLE;
                    endcase
                end
            end
            kwm_pkg::S_APPEND: n_state = kwm_pkg::S_IDLE;
            kwm_pkg::S_SCAN: begin
                s_ctl.cand = r_pv;
                if (32'(r_idx) == NUM_LISTS - 1) begin
                    n_state = kwm_pkg::S_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            kwm_pkg::S_LAST: begin
                s_ctl.cand = r_pv;
                n_state    = kwm_pkg::S_DONE;
            end
            kwm_pkg::S_DONE: n_state = kwm_pkg::S_IDLE;
            default: n_state = kwm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (s_accept) begin
            r_id_ok <= (32'(i_list_id) < NUM_LISTS);
            r_value <= i_value;
        end
        r_pidx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == kwm_pkg::S_SCAN) && s_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || s_clear) begin
            for (int k = 0; k < NUM_LISTS; k++) begin
                r_rp[k] <= '0;
                r_wp[k] <= '0;
            end
        end else begin
            if (s_we) begin
                r_wp[r_idx] <= r_wp[r_idx] + 1'b1;
            end
            if (s_pop) begin
                r_rp[s_best_idx] <= r_rp[s_best_idx] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (r_state == kwm_pkg::S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kwm_pkg::S_DONE) begin
            o_out_value <= s_found ? s_best : '0;
            o_out_list  <= s_found ? 3'(s_best_idx) : '0;
            o_all_empty <= !s_found;
        end
    end

    kwm_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(r_value),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    kwm_best #(
        .LW(LW)
    ) u_best (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (s_ctl),
        .i_data (s_rdata),
        .i_idx  (r_pidx),
        .o_found(s_found),
        .o_value(s_best),
        .o_idx  (s_best_idx)
    );

endmodule

### tb/tb_k_way_sorted_merge_top.sv
`timescale 1ns / 100ps
// tb_k_way_sorted_merge_top: self-checking bench for the k-way sorted merge engine.
// Drives append/take/clear words and checks every take against a local list model or a scripted expected result.
// Depends on kwm_pkg and k_way_sorted_merge_top.
module tb_k_way_sorted_merge_top;

    localparam int NUM_LISTS   = 8;
    localparam int LIST_DEPTH  = 64;
    localparam int TAKE_CYCLES = NUM_LISTS + 3;
    localparam int TOTAL_WORDS = 1350;
    localparam int QUIET_TAIL  = 150;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  list;
        logic        empty;
    } t_take;

    typedef struct packed {
        kwm_pkg::t_action act;
        logic [2:0]       lid;
        logic [31:0]      val;
        logic             typed;
        t_take            want;
    } t_row;

    localparam t_take NO_TAKE = '0;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  i_action    = kwm_pkg::ACT_NONE;
    logic [2:0]  i_list_id   = 3'd0;
    logic [31:0] i_value     = 32'd0;
    logic        busy;
    logic        o_strobe;
    logic [31:0] o_out_value;
    logic [2:0]  o_out_list;
    logic        o_all_empty;

    logic [31:0] list_mem [NUM_LISTS][LIST_DEPTH];
    int unsigned head_pos [NUM_LISTS];
    int unsigned tail_pos [NUM_LISTS];
    longint      run_val  [NUM_LISTS];
    int unsigned run_step;
    t_take       pending_takes [$];
    int          mismatches = 0;
    int          effective_words = 0;

    // tie on equal heads goes to the lower list
    t_row merge_script [25] = '{
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 1'b1}},
        '{kwm_pkg::ACT_NONE,   3'd6, 32'hFFFF_FFFF, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd0, 32'h8000_0000, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd7, 32'h7FFF_FFFF, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd3, 32'h8000_0000, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd5, 32'h0000_0000, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd5, 32'hFFFF_FFFF, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h8000_0000, 3'd0, 1'b0}},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h8000_0000, 3'd3, 1'b0}},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd5, 1'b0}},
        '{kwm_pkg::ACT_APPEND, 3'd3, 32'h0000_0005, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 3'd5, 1'b0}},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0005, 3'd3, 1'b0}},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 3'd7, 1'b0}},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 1'b1}},
        '{kwm_pkg::ACT_APPEND, 3'd2, 32'h0000_0001, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd6, 32'h0000_0001, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd1, 32'h0000_0002, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_TAKE,   3'd4, 32'h0000_0000, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_CLEAR,  3'd0, 32'h0000_0000, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 3'd0, 1'b1}},
        '{kwm_pkg::ACT_APPEND, 3'd4, 32'hAAAA_AAAA, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_APPEND, 3'd4, 32'h5555_5555, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_TAKE,   3'd7, 32'hFFFF_FFFF, 1'b0, NO_TAKE},
        '{kwm_pkg::ACT_TAKE,   3'd0, 32'h0000_0000, 1'b0, NO_TAKE}
    };

    k_way_sorted_merge_top #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_list_id   (i_list_id),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_out_value (o_out_value),
        .o_out_list  (o_out_list),
        .o_all_empty (o_all_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // returns 1 when the word yields a take result
    function automatic bit merge_predict(input kwm_pkg::t_action act, input logic [2:0] lid,
                                         input logic [31:0] val, output t_take res,
                                         output bit changed);
        bit found;
        bit has_res;
        int best;
        res     = '0;
        changed = 1'b0;
        found   = 1'b0;
        has_res = 1'b0;
        best    = 0;
        case (act)
            kwm_pkg::ACT_APPEND: begin
                if (tail_pos[lid] < LIST_DEPTH) begin
                    list_mem[lid][tail_pos[lid]] = val;
                    tail_pos[lid]++;
                    changed = 1'b1;
                end
            end
            kwm_pkg::ACT_CLEAR: begin
                for (int i = 0; i < NUM_LISTS; i++) begin
                    head_pos[i] = 0;
                    tail_pos[i] = 0;
                end
                changed = 1'b1;
            end
            kwm_pkg::ACT_TAKE: begin
                for (int i = 0; i < NUM_LISTS; i++) begin
                    if (head_pos[i] < tail_pos[i]) begin
                        if (!found || $signed(list_mem[i][head_pos[i]]) <
                                      $signed(list_mem[best][head_pos[best]])) begin
                            found = 1'b1;
                            best  = i;
                        end
                    end
                end
                if (found) begin
                    res.value = list_mem[best][head_pos[best]];
                    res.list  = best[2:0];
                    head_pos[best]++;
                end else begin
                    res.empty = 1'b1;
                end
                changed = 1'b1;
                has_res = 1'b1;
            end
            default: begin
            end
        endcase
        return has_res;
    endfunction

    function automatic logic [31:0] next_value(input int lst);
        run_val[lst] += longint'($urandom_range(0, run_step));
        if (run_val[lst] > 64'sd2147483647)
            run_val[lst] = 64'sd2147483647;
        return run_val[lst][31:0];
    endfunction

    task automatic put_word(input kwm_pkg::t_action act, input logic [2:0] lid,
                            input logic [31:0] val, input bit typed, input t_take want);
        t_take got;
        bit    has_res;
        bit    changed;
        start     <= 1'b1;
        i_action  <= act;
        i_list_id <= lid;
        i_value   <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        has_res = merge_predict(act, lid, val, got, changed);
        if (has_res)
            pending_takes = {pending_takes, (typed ? want : got)};
        if (changed)
            effective_words++;
    endtask

    task automatic sender_gap(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_takes;
        start <= 1'b0;
        do @(posedge i_clk); while (pending_takes.size() != 0);
    endtask

    task automatic rand_word(input kwm_pkg::t_action act, input logic [2:0] lid,
                             input logic [31:0] val, input bit gappy);
        if ($urandom_range(0, 24) == 0)
            put_word(kwm_pkg::ACT_NONE, 3'($urandom), $urandom, 1'b0, NO_TAKE);
        put_word(act, lid, val, 1'b0, NO_TAKE);
        if (gappy && effective_words < TOTAL_WORDS - QUIET_TAIL && $urandom_range(0, 4) == 0)
            sender_gap($urandom_range(1, 19));
    endtask

    // one fill-then-merge pass, sometimes broken by a mid-merge clear or no clear
    task automatic run_session;
        int cnt [NUM_LISTS];
        int left;
        int n_takes;
        int pick;
        int style;
        bit gappy;
        bit narrow;
        style    = $urandom_range(0, 9);
        gappy    = ($urandom_range(0, 2) != 0);
        narrow   = (style < 4);
        run_step = narrow ? $urandom_range(0, 3) : $urandom_range(1, 32'h00FF_FFFF);
        left     = 0;
        for (int i = 0; i < NUM_LISTS; i++) begin
            cnt[i] = $urandom_range(0, 6);
            if (style == 9 && $urandom_range(0, 3) == 0)
                cnt[i] = $urandom_range(60, 70);
            run_val[i] = narrow ? longint'($urandom_range(0, 10)) - 5
                                : longint'($signed($urandom));
            left += cnt[i];
        end
        if (style != 8)
            rand_word(kwm_pkg::ACT_CLEAR, 3'($urandom), $urandom, gappy);
        while (left > 0) begin
            pick = $urandom_range(0, NUM_LISTS - 1);
            if (cnt[pick] != 0) begin
                cnt[pick]--;
                left--;
                rand_word(kwm_pkg::ACT_APPEND, pick[2:0],
                          ($urandom_range(0, 19) == 0) ? $urandom : next_value(pick), gappy);
            end
        end
        n_takes = $urandom_range(0, 2);
        for (int i = 0; i < NUM_LISTS; i++)
            n_takes += tail_pos[i] - head_pos[i];
        for (int k = 0; k < n_takes; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                pick = $urandom_range(0, NUM_LISTS - 1);
                rand_word(kwm_pkg::ACT_APPEND, pick[2:0], next_value(pick), gappy);
                n_takes++;
            end
            if (style == 7 && k == n_takes / 2)
                rand_word(kwm_pkg::ACT_CLEAR, 3'($urandom), $urandom, gappy);
            rand_word(kwm_pkg::ACT_TAKE, 3'($urandom), $urandom, gappy);
        end
        if (effective_words < TOTAL_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            drain_takes();
    endtask

    always @(posedge i_clk) begin
        t_take want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_takes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual value=%h list=%0d empty=%b",
                         $time, o_out_value, o_out_list, o_all_empty);
                mismatches++;
            end else begin
                want = pending_takes.pop_front();
                if (o_out_value !== want.value) begin
                    $display("%0t: out_value expected %h actual %h",
                             $time, want.value, o_out_value);
                    mismatches++;
                end
                if (o_out_list !== want.list) begin
                    $display("%0t: out_list expected %0d actual %0d",
                             $time, want.list, o_out_list);
                    mismatches++;
                end
                if (o_all_empty !== want.empty) begin
                    $display("%0t: all_empty expected %b actual %b",
                             $time, want.empty, o_all_empty);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_LISTS; i++) begin
            head_pos[i] = 0;
            tail_pos[i] = 0;
            run_val[i]  = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (merge_script[r]) begin
            put_word(merge_script[r].act, merge_script[r].lid, merge_script[r].val,
                     merge_script[r].typed, merge_script[r].want);
            if (r % 4 == 3)
                sender_gap($urandom_range(1, 19));
        end
        drain_takes();
        while (effective_words < TOTAL_WORDS)
            run_session();
        start <= 1'b0;
        while (pending_takes.size() != 0)
            @(posedge i_clk);
        repeat (TAKE_CYCLES + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
